>>> hdl/sct_pkg.sv
`timescale 1ns / 1ps
// Package for the sequence completion tracker: opcodes, status codes,
// register indexes, controller states and the cell control bundle.
// No dependencies.
package sct_pkg;

  localparam int FIELD_W = 48;

  localparam logic [1:0] OP_INIT     = 2'd0;
  localparam logic [1:0] OP_ALLOC    = 2'd1;
  localparam logic [1:0] OP_FINISH   = 2'd2;
  localparam logic [1:0] OP_RECOVERY = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_BAD   = 2'd3;

  localparam logic [2:0] REG_RECORD_PRESENT  = 3'd0;
  localparam logic [2:0] REG_RECORD_LAST     = 3'd1;
  localparam logic [2:0] REG_RECORD_FIRST    = 3'd2;
  localparam logic [2:0] REG_FLUSH_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_RESERVATION     = 3'd4;

  localparam logic [15:0] FLUSH_THRESHOLD_RST = 16'd100;
  localparam logic [15:0] RESERVATION_RST     = 16'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETIRE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> hdl/sequence_completion_tracker.sv
`timescale 1ns / 1ps
// Top level of the sequence completion tracker: controller, marks and a
// chain of sct_cell done bits. Depends on sct_pkg and sct_cell.
//
//  port group | dir | carries
//  s_*        | in  | command word: tuser opcode, tdata finished_seq
//  m_*        | out | result word: tuser status and sync_write, tdata values
//  cfg_*      | in  | register write: index and data, no read-back
//
// Initialize, allocate, recovery done and a finish out of range pass from
// accept through ST_EXEC and ST_EMIT to the output register. A finish in range
// also passes through ST_RETIRE: the retire walk shifts the cell chain by one
// slot a cycle. One command is in work at a time; the next is taken while the
// previous result waits in the output register.
// Reset is synchronous; it clears the window and marks and returns the config registers to their defaults.
module sequence_completion_tracker #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SEQ_BITS     = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // [47:0] finished_seq
  input  logic [1:0]   s_tuser,   // [1:0] opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // result_value, sync_last_finished,
                                  // sync_first_available, oldest_unfinished
  output logic [2:0]   m_tuser,   // [1:0] status, [2] sync_write
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  function automatic logic [SEQ_BITS-1:0] to_seq(input logic [47:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[SEQ_BITS-1:0];
  endfunction

  function automatic logic [47:0] to_field(input logic [SEQ_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[47:0];
  endfunction

  logic        record_present;
  logic [47:0] record_last_finished;
  logic [47:0] record_first_available;
  logic [15:0] flush_threshold;
  logic [15:0] reservation_size;

  sct_pkg::state_t state, state_next;
  logic [1:0]          op, op_next;
  logic [SEQ_BITS-1:0] fseq, fseq_next;
  logic [SEQ_BITS-1:0] oldest_open, oldest_open_next;
  logic [SEQ_BITS-1:0] last_given, last_given_next;
  logic [SEQ_BITS-1:0] mark_lf, mark_lf_next;
  logic [SEQ_BITS-1:0] mark_fa, mark_fa_next;
  logic                recovery_done, recovery_done_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [1:0]          res_status, res_status_next;
  logic [SEQ_BITS-1:0] res_value, res_value_next;
  logic                res_sync, res_sync_next;
  logic                m_tvalid_next;
  logic [191:0]        m_tdata_next;
  logic [2:0]          m_tuser_next;

  sct_pkg::cell_ctrl_t     cell_ctrl;
  logic                    set_en;
  logic [IDX_W-1:0]        slot;
  logic [WINDOW_DEPTH-1:0] done;
  logic [WINDOW_DEPTH-1:0] up_vec;

  assign s_tready = (state == sct_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_present         <= 1'b0;
      record_last_finished   <= '0;
      record_first_available <= 48'd1;
      flush_threshold        <= sct_pkg::FLUSH_THRESHOLD_RST;
      reservation_size       <= sct_pkg::RESERVATION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sct_pkg::REG_RECORD_PRESENT:  record_present         <= cfg_data[0];
        sct_pkg::REG_RECORD_LAST:     record_last_finished   <= cfg_data;
        sct_pkg::REG_RECORD_FIRST:    record_first_available <= cfg_data;
        sct_pkg::REG_FLUSH_THRESHOLD: flush_threshold        <= cfg_data[15:0];
        sct_pkg::REG_RESERVATION:     reservation_size       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sct_pkg::ST_IDLE;
      oldest_open   <= '0;
      last_given    <= '0;
      mark_lf       <= '0;
      mark_fa       <= '0;
      recovery_done <= 1'b0;
      count         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      oldest_open   <= oldest_open_next;
      last_given    <= last_given_next;
      mark_lf       <= mark_lf_next;
      mark_fa       <= mark_fa_next;
      recovery_done <= recovery_done_next;
      count         <= count_next;
      m_tvalid      <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    fseq       <= fseq_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_sync   <= res_sync_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

  always_comb begin
    logic [SEQ_BITS-1:0] lf;
    logic [SEQ_BITS-1:0] fa;
    logic [SEQ_BITS-1:0] given;
    logic [SEQ_BITS-1:0] off;
    logic [SEQ_BITS-1:0] lag;

    state_next         = state;
    op_next            = op;
    fseq_next          = fseq;
    oldest_open_next   = oldest_open;
    last_given_next    = last_given;
    mark_lf_next       = mark_lf;
    mark_fa_next       = mark_fa;
    recovery_done_next = recovery_done;
    count_next         = count;
    res_status_next    = res_status;
    res_value_next     = res_value;
    res_sync_next      = res_sync;
    m_tvalid_next      = m_tvalid && !m_tready;
    m_tdata_next       = m_tdata;
    m_tuser_next       = m_tuser;
    cell_ctrl          = '0;
    set_en             = 1'b0;
    slot               = '0;

    lf    = record_present ? to_seq(record_last_finished) : '0;
    fa    = record_present ? to_seq(record_first_available) : SEQ_BITS'(1);
    given = last_given + SEQ_BITS'(1);
    off   = fseq - oldest_open;
    lag   = oldest_open - mark_lf;

    unique case (state)
      sct_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          op_next    = s_tuser;
          fseq_next  = to_seq(s_tdata);
          state_next = sct_pkg::ST_EXEC;
        end
      end
      sct_pkg::ST_EXEC: begin
        res_status_next = sct_pkg::STATUS_OK;
        res_value_next  = '0;
        res_sync_next   = 1'b0;
        state_next      = sct_pkg::ST_EMIT;
        unique case (op)
          sct_pkg::OP_INIT: begin
            mark_lf_next     = lf;
            mark_fa_next     = fa;
            oldest_open_next = fa;
            last_given_next  = fa - SEQ_BITS'(1);
            count_next       = '0;
            cell_ctrl.clr    = 1'b1;
            res_value_next   = lf;
          end
          sct_pkg::OP_ALLOC: begin
            if (count == CNT_W'(WINDOW_DEPTH)) begin
              res_status_next = sct_pkg::STATUS_FULL;
            end else begin
              last_given_next = given;
              count_next      = count + CNT_W'(1);
              res_value_next  = given;
              if (given >= mark_fa) begin
                res_sync_next = 1'b1;
                if (recovery_done) begin
                  mark_lf_next = oldest_open - SEQ_BITS'(1);
                end
                mark_fa_next = given + SEQ_BITS'(reservation_size);
              end
            end
          end
          sct_pkg::OP_FINISH: begin
            if (off >= SEQ_BITS'(count)) begin
              res_status_next = sct_pkg::STATUS_RANGE;
            end else begin
              set_en     = 1'b1;
              slot       = off[IDX_W-1:0];
              state_next = sct_pkg::ST_RETIRE;
            end
          end
          sct_pkg::OP_RECOVERY: begin
            recovery_done_next = 1'b1;
            res_sync_next      = 1'b1;
            mark_lf_next       = oldest_open - SEQ_BITS'(1);
            mark_fa_next       = last_given + SEQ_BITS'(reservation_size);
          end
          default: ;
        endcase
      end
      sct_pkg::ST_RETIRE: begin
        if (count != '0 && done[0]) begin
          cell_ctrl.shift  = 1'b1;
          count_next       = count - CNT_W'(1);
          oldest_open_next = oldest_open + SEQ_BITS'(1);
        end else begin
          state_next = sct_pkg::ST_EMIT;
          if (recovery_done && oldest_open > mark_lf &&
              lag > SEQ_BITS'(flush_threshold)) begin
            res_sync_next = 1'b1;
            mark_lf_next  = oldest_open - SEQ_BITS'(1);
            mark_fa_next  = last_given + SEQ_BITS'(reservation_size);
          end
        end
      end
      sct_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tuser_next  = {res_sync, res_status};
          m_tdata_next  = {to_field(oldest_open),
                           res_sync ? to_field(mark_fa) : 48'd0,
                           res_sync ? to_field(mark_lf) : 48'd0,
                           to_field(res_value)};
          state_next    = sct_pkg::ST_IDLE;
        end
      end
      default: state_next = sct_pkg::ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == WINDOW_DEPTH - 1) begin : g_tail
      assign up_vec[i] = 1'b0;
    end else begin : g_link
      assign up_vec[i] = done[i+1];
    end

    sct_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cell_ctrl),
      .set  (set_en && (slot == IDX_W'(i))),
      .up   (up_vec[i]),
      .done (done[i])
    );
  end

endmodule

>>> hdl/sct_cell.sv
`timescale 1ns / 1ps
// One done bit of the completion window; shifts toward the oldest slot.
// Depends on sct_pkg (cell_ctrl_t).
module sct_cell (
  input  logic                clk,
  input  logic                rst,
  input  sct_pkg::cell_ctrl_t ctrl,
  input  logic                set,
  input  logic                up,
  output logic                done
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      done <= 1'b0;
    end else if (ctrl.shift) begin
      done <= up;
    end else if (set) begin
      done <= 1'b1;
    end
  end

endmodule

>>> hdl/sct_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the completion tracker,
// bound to sequence_completion_tracker. Depends on sct_pkg.
module sct_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic [2:0]   m_tuser
);

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] != sct_pkg::STATUS_BAD)
    else $error("undefined status code");

  a_sync_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tdata[143:48] == 96'd0)
    else $error("sync marks set without sync_write");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != sct_pkg::STATUS_OK
      |-> !m_tuser[2] && m_tdata[47:0] == 48'd0)
    else $error("rejected command raised sync or value");

endmodule

bind sequence_completion_tracker sct_checker u_sct_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
